// ----- design/cst_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the CPU scheduler tick engine.
// No dependencies; used by the controller, datapath, top level and testbench.
package cst_pkg;

  localparam int MaxProcs = 16;
  localparam int SlotBits = 4;
  localparam int TimeBits = 16;
  localparam int CntBits  = 5;

  localparam logic [1:0] ReqLoad    = 2'd0;
  localparam logic [1:0] ReqTick    = 2'd1;
  localparam logic [1:0] ReqRestart = 2'd2;

  localparam logic [2:0] ModeFcfs  = 3'd0;
  localparam logic [2:0] ModeSjf   = 3'd1;
  localparam logic [2:0] ModeSrtf  = 3'd2;
  localparam logic [2:0] ModePrio  = 3'd3;
  localparam logic [2:0] ModePprio = 3'd4;
  localparam logic [2:0] ModeRr    = 3'd5;

  localparam logic [1:0] AddrMode    = 2'd0;
  localparam logic [1:0] AddrQuantum = 2'd1;
  localparam logic [1:0] AddrCount   = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StAdmit,
    StInsScan,
    StInsShift,
    StSched,
    StPreScan,
    StPreShift,
    StDispatch,
    StRun,
    StOut
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       start;     // latch request
    logic       do_load;
    logic       do_restart;
    logic       scan_clr;  // reset scan index
    logic       scan_inc;
    logic       admit;     // mark slot admitted and build a new entry
    logic       build_cur; // new entry from the running process
    logic       ins_init;  // start insert position search
    logic       ins_step;  // advance insert position
    logic       shift_step;// shift one entry toward the tail
    logic       ins_write; // place new entry
    logic       dispatch;  // pop head into the CPU
    logic       preempt;   // drop current, mark switched
    logic       run;       // execute one unit
    logic       finish_nop;// result with nothing run
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       active;    // done_count below process count
    logic       scan_last;
    logic       admit_hit;
    logic       ins_done;  // insert position found
    logic       shift_done;
    logic       cur_valid;
    logic       q_nonempty;
    logic       swap;
  } status_t;

endpackage

// ----- design/cst_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the tick engine.
// Depends on cst_pkg; drives commands into cst_datapath.
module cst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_busy_i,
  input  cst_pkg::status_t st_i,
  output logic             in_stall_o,
  output cst_pkg::cmd_t    cmd_o
);

  cst_pkg::state_e state_q, state_d;
  logic            from_pre_q, from_pre_d;

  assign in_stall_o = (state_q != cst_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cst_pkg::StIdle;
      from_pre_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      from_pre_q <= from_pre_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    from_pre_d = from_pre_q;
    case (state_q)
      cst_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = cst_pkg::StAdmit;
        end
      end
      cst_pkg::StAdmit: begin
        if (st_i.req != cst_pkg::ReqTick || !st_i.active) begin
          state_d = cst_pkg::StOut;
        end else if (st_i.admit_hit) begin
          state_d    = cst_pkg::StInsScan;
          from_pre_d = 1'b0;
        end else if (st_i.scan_last) begin
          state_d = cst_pkg::StSched;
        end
      end
      cst_pkg::StInsScan: begin
        if (st_i.ins_done) begin
          state_d = from_pre_q ? cst_pkg::StPreShift : cst_pkg::StInsShift;
        end
      end
      cst_pkg::StInsShift: begin
        if (st_i.shift_done) begin
          state_d = st_i.scan_last ? cst_pkg::StSched : cst_pkg::StAdmit;
        end
      end
      cst_pkg::StSched: begin
        if (!st_i.cur_valid && st_i.q_nonempty) begin
          state_d = cst_pkg::StDispatch;
        end else if (st_i.cur_valid && st_i.q_nonempty && st_i.swap) begin
          state_d    = cst_pkg::StInsScan;
          from_pre_d = 1'b1;
        end else begin
          state_d = cst_pkg::StRun;
        end
      end
      cst_pkg::StPreScan: state_d = cst_pkg::StInsScan;
      cst_pkg::StPreShift: begin
        if (st_i.shift_done) begin
          state_d = cst_pkg::StDispatch;
        end
      end
      cst_pkg::StDispatch: state_d = cst_pkg::StRun;
      cst_pkg::StRun:      state_d = cst_pkg::StOut;
      cst_pkg::StOut: begin
        if (!out_busy_i) begin
          state_d = cst_pkg::StIdle;
        end
      end
      default: state_d = cst_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      cst_pkg::StIdle: begin
        cmd_o.start    = in_valid_i;
        cmd_o.scan_clr = in_valid_i;
      end
      cst_pkg::StAdmit: begin
        if (st_i.req == cst_pkg::ReqLoad) begin
          cmd_o.do_load = 1'b1;
        end
        if (st_i.req == cst_pkg::ReqRestart) begin
          cmd_o.do_restart = 1'b1;
        end
        if (st_i.req != cst_pkg::ReqTick || !st_i.active) begin
          cmd_o.finish_nop = 1'b1;
        end else if (st_i.admit_hit) begin
          cmd_o.admit    = 1'b1;
          cmd_o.ins_init = 1'b1;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      cst_pkg::StInsScan: cmd_o.ins_step = !st_i.ins_done;
      cst_pkg::StInsShift: begin
        if (st_i.shift_done) begin
          cmd_o.ins_write = 1'b1;
          cmd_o.scan_inc  = 1'b1;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      cst_pkg::StSched: begin
        if (st_i.cur_valid && st_i.q_nonempty && st_i.swap) begin
          cmd_o.build_cur = 1'b1;
          cmd_o.preempt   = 1'b1;
          cmd_o.ins_init  = 1'b1;
        end
      end
      cst_pkg::StPreShift: begin
        if (st_i.shift_done) begin
          cmd_o.ins_write = 1'b1;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      cst_pkg::StDispatch: cmd_o.dispatch = 1'b1;
      cst_pkg::StRun: begin
        cmd_o.run = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- design/cst_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the tick engine: slot tables, ready queue, CPU state and results.
// Depends on cst_pkg; steered by cst_ctrl.
module cst_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cst_pkg::cmd_t                 cmd_i,
  output cst_pkg::status_t              st_o,
  input  logic [2:0]                    mode_i,
  input  logic [7:0]                    quantum_i,
  input  logic [cst_pkg::CntBits-1:0]   count_i,
  input  logic [1:0]                    req_type_i,
  input  logic [cst_pkg::SlotBits-1:0]  slot_i,
  input  logic [15:0]                   arrival_time_i,
  input  logic [15:0]                   burst_len_i,
  input  logic [7:0]                    priority_req_i,
  input  logic                          out_take_i,
  output logic                          out_valid_o,
  output logic [3:0]                    running_slot_o,
  output logic                          idle_o,
  output logic                          switched_o,
  output logic                          completed_o,
  output logic [15:0]                   turnaround_o,
  output logic [15:0]                   waiting_o,
  output logic                          all_done_o
);

  localparam int SB = cst_pkg::SlotBits;
  localparam int CB = cst_pkg::CntBits;
  localparam int TB = cst_pkg::TimeBits;
  localparam int MP = cst_pkg::MaxProcs;

  // Request latch.
  logic [1:0]  req_q;
  logic [SB-1:0] slot_q;
  logic [15:0] arr_in_q, bur_in_q;
  logic [7:0]  pri_in_q;

  logic [15:0] slot_arr_q [MP];
  logic [15:0] slot_bur_q [MP];
  logic [7:0]  slot_pri_q [MP];
  logic [MP-1:0] admitted_q;

  logic [SB-1:0] q_slot_q [MP];
  logic [15:0]   q_rem_q  [MP];
  logic [CB-1:0] q_cnt_q;

  logic          cur_v_q;
  logic [SB-1:0] cur_slot_q;
  logic [15:0]   cur_rem_q;
  logic [7:0]    slice_q;
  logic [TB-1:0] time_q;
  logic [CB-1:0] done_q;

  logic [CB-1:0] scan_q;
  logic [CB-1:0] pos_q;
  logic [CB-1:0] sh_q;
  logic [SB-1:0] new_slot_q;
  logic [15:0]   new_rem_q;
  logic          sw_q;

  logic [CB-1:0] n_eff;
  logic [SB-1:0] scan_idx, pos_idx, sh_idx;
  logic [15:0]   new_key, pos_key, head_key, cur_key;
  logic          sorted;

  assign n_eff    = (count_i > CB'(MP)) ? CB'(MP) : count_i;
  assign scan_idx = scan_q[SB-1:0];
  assign pos_idx  = pos_q[SB-1:0];
  assign sh_idx   = sh_q[SB-1:0];
  assign sorted   = (mode_i == cst_pkg::ModeSjf) || (mode_i == cst_pkg::ModeSrtf) ||
                    (mode_i == cst_pkg::ModePrio) || (mode_i == cst_pkg::ModePprio);

  function automatic logic [15:0] key_of(input logic [2:0] m, input logic [15:0] rem,
                                         input logic [7:0] pri);
    if (m == cst_pkg::ModeSjf || m == cst_pkg::ModeSrtf) begin
      return rem;
    end else if (m == cst_pkg::ModePrio || m == cst_pkg::ModePprio) begin
      return {8'd0, pri};
    end
    return 16'd0;
  endfunction

  assign new_key  = key_of(mode_i, new_rem_q, slot_pri_q[new_slot_q]);
  assign pos_key  = key_of(mode_i, q_rem_q[pos_idx], slot_pri_q[q_slot_q[pos_idx]]);
  assign head_key = key_of(mode_i, q_rem_q[0], slot_pri_q[q_slot_q[0]]);
  assign cur_key  = key_of(mode_i, cur_rem_q, slot_pri_q[cur_slot_q]);

  always_comb begin
    st_o           = '0;
    st_o.req       = req_q;
    st_o.active    = done_q < n_eff;
    st_o.scan_last = (scan_q + CB'(1) >= n_eff) || (scan_q >= n_eff);
    st_o.admit_hit = (scan_q < n_eff) && !admitted_q[scan_idx] &&
                     (TB'(slot_arr_q[scan_idx]) <= time_q);
    st_o.ins_done  = !sorted || (pos_q >= q_cnt_q) || (pos_key > new_key);
    st_o.shift_done = (sh_q <= pos_q);
    st_o.cur_valid = cur_v_q;
    st_o.q_nonempty = q_cnt_q != '0;
    case (mode_i)
      cst_pkg::ModeSrtf:  st_o.swap = cur_rem_q > q_rem_q[0];
      cst_pkg::ModePprio: st_o.swap = cur_key > head_key;
      cst_pkg::ModeRr:    st_o.swap = slice_q >= ((quantum_i == 8'd0) ? 8'd1 : quantum_i);
      default:            st_o.swap = 1'b0;
    endcase
  end

  // Slot tables: no reset, written by load requests.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_load) begin
      slot_arr_q[slot_q] <= arr_in_q;
      slot_bur_q[slot_q] <= bur_in_q;
      slot_pri_q[slot_q] <= pri_in_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      slot_q   <= slot_i;
      arr_in_q <= arrival_time_i;
      bur_in_q <= burst_len_i;
      pri_in_q <= priority_req_i;
    end
    if (cmd_i.admit) begin
      new_slot_q <= scan_idx;
      new_rem_q  <= slot_bur_q[scan_idx];
    end else if (cmd_i.build_cur) begin
      new_slot_q <= cur_slot_q;
      new_rem_q  <= cur_rem_q;
    end
    if (cmd_i.ins_write) begin
      q_slot_q[pos_idx] <= new_slot_q;
      q_rem_q[pos_idx]  <= new_rem_q;
    end else if (cmd_i.shift_step) begin
      q_slot_q[sh_idx] <= q_slot_q[sh_idx - SB'(1)];
      q_rem_q[sh_idx]  <= q_rem_q[sh_idx - SB'(1)];
    end else if (cmd_i.dispatch) begin
      for (int k = 0; k < MP - 1; k++) begin
        q_slot_q[k] <= q_slot_q[k+1];
        q_rem_q[k]  <= q_rem_q[k+1];
      end
    end
  end

  logic [15:0] rem_next;
  logic [TB-1:0] fin;
  logic [16:0] tat_w, wt_w;
  assign rem_next = (cur_rem_q != 16'd0) ? cur_rem_q - 16'd1 : 16'd0;
  assign fin      = (time_q != '1) ? time_q + TB'(1) : time_q;
  assign tat_w    = (fin >= TB'(slot_arr_q[cur_slot_q])) ?
                    17'(fin - TB'(slot_arr_q[cur_slot_q])) : 17'd0;
  assign wt_w     = (tat_w >= {1'b0, slot_bur_q[cur_slot_q]}) ?
                    tat_w - {1'b0, slot_bur_q[cur_slot_q]} : 17'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0; admitted_q <= '0; q_cnt_q <= '0; cur_v_q <= 1'b0;
      cur_slot_q <= '0; cur_rem_q <= '0; slice_q <= '0; time_q <= '0;
      done_q <= '0; scan_q <= '0; pos_q <= '0; sh_q <= '0; sw_q <= 1'b0;
      out_valid_o <= 1'b0; running_slot_o <= '0; idle_o <= 1'b0; switched_o <= 1'b0;
      completed_o <= 1'b0; turnaround_o <= '0; waiting_o <= '0;
    end else begin
      if (out_take_i) begin
        out_valid_o <= 1'b0;
      end
      if (cmd_i.start) begin
        req_q <= req_type_i;
        sw_q  <= 1'b0;
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_q <= scan_q + CB'(1);
      end
      if (cmd_i.admit) begin
        admitted_q[scan_idx] <= 1'b1;
      end
      if (cmd_i.ins_init) begin
        pos_q <= sorted ? '0 : q_cnt_q;
        sh_q  <= q_cnt_q;
      end else if (cmd_i.ins_step) begin
        pos_q <= pos_q + CB'(1);
      end else if (cmd_i.shift_step) begin
        sh_q <= sh_q - CB'(1);
      end
      if (cmd_i.ins_write) begin
        q_cnt_q <= q_cnt_q + CB'(1);
      end
      if (cmd_i.preempt) begin
        cur_v_q <= 1'b0;
        sw_q    <= 1'b1;
      end
      if (cmd_i.dispatch) begin
        cur_slot_q <= q_slot_q[0];
        cur_rem_q  <= q_rem_q[0];
        cur_v_q    <= 1'b1;
        slice_q    <= '0;
        q_cnt_q    <= q_cnt_q - CB'(1);
      end
      if (cmd_i.finish_nop) begin
        out_valid_o <= 1'b1; running_slot_o <= '0; idle_o <= 1'b1;
        switched_o <= 1'b0; completed_o <= 1'b0; turnaround_o <= '0; waiting_o <= '0;
      end
      if (cmd_i.run) begin
        out_valid_o <= 1'b1;
        switched_o  <= sw_q;
        if (time_q != '1) begin
          time_q <= time_q + TB'(1);
        end
        if (cur_v_q) begin
          idle_o         <= 1'b0;
          running_slot_o <= cur_slot_q;
          cur_rem_q      <= rem_next;
          if (rem_next == 16'd0) begin
            completed_o  <= 1'b1;
            turnaround_o <= tat_w[16] ? 16'hFFFF : tat_w[15:0];
            waiting_o    <= wt_w[16] ? 16'hFFFF : wt_w[15:0];
            cur_v_q      <= 1'b0;
            slice_q      <= '0;
            if (done_q != '1) begin
              done_q <= done_q + CB'(1);
            end
          end else begin
            completed_o <= 1'b0; turnaround_o <= '0; waiting_o <= '0;
            if (slice_q != 8'hFF) begin
              slice_q <= slice_q + 8'd1;
            end
          end
        end else begin
          idle_o <= 1'b1; running_slot_o <= '0; completed_o <= 1'b0;
          turnaround_o <= '0; waiting_o <= '0;
        end
      end
      if (cmd_i.do_restart) begin
        admitted_q <= '0; q_cnt_q <= '0; cur_v_q <= 1'b0; cur_slot_q <= '0;
        cur_rem_q <= '0; slice_q <= '0; time_q <= '0; done_q <= '0;
      end
    end
  end

  // Done flag follows the live count so a config write is seen at once.
  assign all_done_o = done_q >= n_eff;

endmodule

// ----- design/cpu_scheduler_tick_engine.sv -----
`timescale 1ns / 1ps
// Top level of the CPU scheduler tick engine: APB registers, controller, datapath.
// Depends on cst_pkg, cst_ctrl and cst_datapath.
//
// Usage: a request enters on in_valid_i/in_stall_o with req_type_i selecting a slot
// load, one scheduler tick, or a restart of the run. Every request yields exactly one
// result on out_valid_o/out_stall_i. Loads write the slot tables; ticks admit arrived
// slots into the ready queue, schedule according to sched_mode and run the CPU for one
// time unit, reporting the slot that ran, a switch, and completion statistics.
// A request is handled one at a time. Loads, restarts, unknown codes and ticks after
// the run is done go from admission straight to their result. A tick walks the slots
// one per cycle, pausing at each admitted slot for the position scan over the queue
// and the single-entry shift that insert it; a preemption adds one more such insert.
// The admission walk and the single-entry queue shifter set how long a tick occupies.
// Reset clears the run state, leaves the slot tables undefined until loaded, and sets
// sched_mode to FCFS, quantum to 2 and process_count to 1. While the receiver stalls,
// the result waits in the output register and no new request is taken.
// Registers sit at byte addresses 0 (sched_mode), 4 (quantum), 8 (process_count).
module cpu_scheduler_tick_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  slot_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] burst_len_i,
  input  logic [7:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  running_slot_o,
  output logic        idle_o,
  output logic        switched_o,
  output logic        completed_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_o,
  output logic        all_done_o
);

  logic [2:0] mode_q;
  logic [7:0] quantum_q;
  logic [4:0] count_q;
  logic       wr;

  cst_pkg::cmd_t    cmd;
  cst_pkg::status_t st;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Configuration registers, written in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= cst_pkg::ModeFcfs;
      quantum_q <= 8'd2;
      count_q   <= 5'd1;
    end else if (wr) begin
      case (paddr[3:2])
        cst_pkg::AddrMode:    mode_q    <= pwdata[2:0];
        cst_pkg::AddrQuantum: quantum_q <= pwdata[7:0];
        cst_pkg::AddrCount:   count_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      cst_pkg::AddrMode:    prdata = {29'd0, mode_q};
      cst_pkg::AddrQuantum: prdata = {24'd0, quantum_q};
      cst_pkg::AddrCount:   prdata = {27'd0, count_q};
      default:              prdata = 32'd0;
    endcase
  end

  // Unknown modes behave as FCFS.
  logic [2:0] mode_eff;
  assign mode_eff = (mode_q > cst_pkg::ModeRr) ? cst_pkg::ModeFcfs : mode_q;

  cst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_busy_i (out_valid_o),
    .st_i       (st),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  cst_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .mode_i         (mode_eff),
    .quantum_i      (quantum_q),
    .count_i        (count_q),
    .req_type_i     (req_type_i),
    .slot_i         (slot_i),
    .arrival_time_i (arrival_time_i),
    .burst_len_i    (burst_len_i),
    .priority_req_i (priority_req_i),
    .out_take_i     (out_valid_o && !out_stall_i),
    .out_valid_o    (out_valid_o),
    .running_slot_o (running_slot_o),
    .idle_o         (idle_o),
    .switched_o     (switched_o),
    .completed_o    (completed_o),
    .turnaround_o   (turnaround_o),
    .waiting_o      (waiting_o),
    .all_done_o     (all_done_o)
  );

endmodule

// ----- design/cst_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the tick engine, bound to the top level.
// Depends only on the top level's ports.
module cst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        idle_o,
  input logic        completed_o,
  input logic [3:0]  running_slot_o,
  input logic [15:0] turnaround_o
);

  // A result waiting under stall stays valid and keeps its turnaround.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(turnaround_o))
    else $error("stalled result changed");

  // An idle result never reports a completion or a slot.
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> !completed_o && running_slot_o == 4'd0)
    else $error("idle result carries run data");

  // An accepted request is not followed by another in the next cycle.
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken at once");

endmodule

bind cpu_scheduler_tick_engine cst_checker u_cst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .idle_o         (idle_o),
  .completed_o    (completed_o),
  .running_slot_o (running_slot_o),
  .turnaround_o   (turnaround_o)
);

// ----- tb/cpu_scheduler_tick_engine_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for cpu_scheduler_tick_engine: random scheduler runs under
// all six policies, checked result by result against a behavioral scheduler model.
// Depends on cst_pkg and the cpu_scheduler_tick_engine RTL.
module cpu_scheduler_tick_engine_test;
  import cst_pkg::*;

  typedef struct packed {
    logic [3:0]  running_slot;
    logic        idle;
    logic        switched;
    logic        completed;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
  } tick_result_t;

  // Behavioral scheduler that keeps its own copy of the run state and predicts one
  // result per accepted request.
  class sched_predictor;
    logic [2:0]   mode;
    logic [7:0]   quantum;
    logic [4:0]   proc_count;
    logic [15:0]  arrival [MaxProcs];
    logic [15:0]  burst [MaxProcs];
    logic [7:0]   prio [MaxProcs];
    bit           admitted [MaxProcs];
    int           q_slot [MaxProcs];
    int           q_rem [MaxProcs];
    int           q_len;
    bit           cpu_busy;
    int           cpu_slot;
    int           cpu_rem;
    int           slice;
    int           now;
    int           done;
    tick_result_t expected_results [$];
    int           errors;

    function new();
      mode = ModeFcfs;
      quantum = 8'd2;
      proc_count = 5'd1;
      errors = 0;
      restart_run();
    endfunction

    function void restart_run();
      foreach (admitted[i]) admitted[i] = 0;
      q_len = 0;
      cpu_busy = 0;
      cpu_slot = 0;
      cpu_rem = 0;
      slice = 0;
      now = 0;
      done = 0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [31:0] value);
      case (addr)
        AddrMode:    mode = value[2:0];
        AddrQuantum: quantum = value[7:0];
        AddrCount:   proc_count = value[4:0];
        default: ;
      endcase
    endfunction

    function int active_count();
      return (proc_count > MaxProcs) ? MaxProcs : int'(proc_count);
    endfunction

    function bit run_finished();
      return done >= active_count();
    endfunction

    function int sort_key(int s, int rem);
      if (mode == ModeSjf || mode == ModeSrtf) return rem;
      if (mode == ModePrio || mode == ModePprio) return prio[s];
      return 0;
    endfunction

    // Sorted policies place a new entry after every entry with an equal key.
    function void enqueue(int s, int rem);
      int pos;
      if (q_len >= MaxProcs) return;
      pos = q_len;
      if (mode >= ModeSjf && mode <= ModePprio) begin
        pos = 0;
        while (pos < q_len && sort_key(q_slot[pos], q_rem[pos]) <= sort_key(s, rem)) pos++;
      end
      for (int k = q_len; k > pos; k--) begin
        q_slot[k] = q_slot[k-1];
        q_rem[k] = q_rem[k-1];
      end
      q_slot[pos] = s;
      q_rem[pos] = rem;
      q_len++;
    endfunction

    function void dispatch_head();
      cpu_slot = q_slot[0];
      cpu_rem = q_rem[0];
      cpu_busy = 1;
      slice = 0;
      for (int k = 1; k < q_len; k++) begin
        q_slot[k-1] = q_slot[k];
        q_rem[k-1] = q_rem[k];
      end
      q_len--;
    endfunction

    function void note_request(logic [1:0] req, logic [3:0] s, logic [15:0] arr,
                               logic [15:0] bur, logic [7:0] pri);
      tick_result_t r;
      bit swap;
      int fin, tat, wt, rs, rr;
      r = '0;
      r.idle = 1'b1;
      if (req == ReqLoad) begin
        arrival[s] = arr;
        burst[s] = bur;
        prio[s] = pri;
      end else if (req == ReqRestart) begin
        restart_run();
      end else if (req == ReqTick && done < active_count()) begin
        for (int j = 0; j < active_count(); j++) begin
          if (!admitted[j] && arrival[j] <= now) begin
            admitted[j] = 1;
            enqueue(j, burst[j]);
          end
        end
        if (!cpu_busy) begin
          if (q_len > 0) dispatch_head();
        end else if (q_len > 0) begin
          swap = 0;
          if (mode == ModeSrtf) swap = cpu_rem > q_rem[0];
          else if (mode == ModePprio) swap = prio[cpu_slot] > prio[q_slot[0]];
          else if (mode == ModeRr) swap = slice >= quantum;
          if (swap) begin
            rs = cpu_slot;
            rr = cpu_rem;
            cpu_busy = 0;
            enqueue(rs, rr);
            dispatch_head();
            r.switched = 1'b1;
          end
        end
        if (cpu_busy) begin
          r.idle = 1'b0;
          r.running_slot = 4'(cpu_slot);
          if (cpu_rem > 0) cpu_rem--;
          if (slice < 255) slice++;
          if (cpu_rem == 0) begin
            fin = (now < 65535) ? now + 1 : 65535;
            tat = (fin >= arrival[cpu_slot]) ? fin - arrival[cpu_slot] : 0;
            wt = (tat >= burst[cpu_slot]) ? tat - burst[cpu_slot] : 0;
            r.completed = 1'b1;
            r.turnaround = 16'(tat);
            r.waiting = 16'(wt);
            cpu_busy = 0;
            slice = 0;
            done++;
          end
        end
        if (now < 65535) now++;
      end
      r.all_done = run_finished();
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t exp_r;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      exp_r = expected_results.pop_front();
      compare_field("running_slot", exp_r.running_slot, got.running_slot);
      compare_field("idle", exp_r.idle, got.idle);
      compare_field("switched", exp_r.switched, got.switched);
      compare_field("completed", exp_r.completed, got.completed);
      compare_field("turnaround", exp_r.turnaround, got.turnaround);
      compare_field("waiting", exp_r.waiting, got.waiting);
      compare_field("all_done", exp_r.all_done, got.all_done);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [3:0]  slot_i;
  logic [15:0] arrival_time_i;
  logic [15:0] burst_len_i;
  logic [7:0]  priority_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  running_slot_o;
  logic        idle_o;
  logic        switched_o;
  logic        completed_o;
  logic [15:0] turnaround_o;
  logic [15:0] waiting_o;
  logic        all_done_o;

  sched_predictor pred = new();
  int  requests_sent = 0;
  // When set, neither side inserts gaps or stalls.
  bit  calm = 0;

  cpu_scheduler_tick_engine i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver stalls in bursts; the value is stable from one rising edge to the next.
  initial begin
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Results are sampled at the falling edge, where outputs and our stall are settled;
  // a result taken there is accepted at the following rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      pred.check_result({running_slot_o, idle_o, switched_o, completed_o,
                         turnaround_o, waiting_o, all_done_o});
  end

  // Sends one request and returns at the rising edge where it was accepted.
  task automatic send_request(logic [1:0] req, logic [3:0] s, logic [15:0] arr,
                              logic [15:0] bur, logic [7:0] pri);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    slot_i <= s;
    arrival_time_i <= arr;
    burst_len_i <= bur;
    priority_req_i <= pri;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    pred.note_request(req, s, arr, bur, pri);
    requests_sent++;
  endtask

  // Holds off the sender until every predicted result has been seen, then lets the
  // engine settle before anything touches the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pred.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Two-phase register write; pready is always high, so the access phase has no wait states.
  task automatic write_reg(logic [1:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {addr, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pred.set_reg(addr, value);
  endtask

  // Loads one slot with random content. Most processes arrive early with short bursts;
  // a few never arrive within a run or run for a very long time.
  task automatic load_random_slot(logic [3:0] s);
    logic [15:0] arr;
    logic [15:0] bur;
    logic [7:0]  pri;
    arr = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
    bur = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535))
                                       : 16'($urandom_range(1, 6));
    pri = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    send_request(ReqLoad, s, arr, bur, pri);
  endtask

  initial begin
    logic [2:0]  cfg_mode;
    logic [7:0]  cfg_quantum;
    logic [4:0]  cfg_count;
    int          episode;
    int          ticks;
    int          extra;
    int          wait_cycles;

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    req_type_i = ReqLoad;
    slot_i = '0;
    arrival_time_i = '0;
    burst_len_i = '0;
    priority_req_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed start: every slot gets loaded at least once so that no tick ever reads an empty
    // slot. Field extremes appear here, then an unknown request code, then a short run
    // under the reset configuration, ticks past completion, and a restart.
    for (int s = 0; s < MaxProcs; s++) begin
      case (s)
        1:       send_request(ReqLoad, 4'(s), 16'hFFFF, 16'hFFFF, 8'hFF);
        2:       send_request(ReqLoad, 4'(s), 16'h0000, 16'h0001, 8'h00);
        3:       send_request(ReqLoad, 4'(s), 16'h5555, 16'hAAAA, 8'h55);
        4:       send_request(ReqLoad, 4'(s), 16'hAAAA, 16'h5555, 8'hAA);
        default: send_request(ReqLoad, 4'(s), 16'($urandom_range(0, 4)),
                              16'($urandom_range(1, 3)), 8'($urandom));
      endcase
    end
    send_request(ReqLoad, 4'd0, 16'd0, 16'd2, 8'd7);
    send_request(2'd3, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF);
    repeat (4) send_request(ReqTick, '0, '0, '0, '0);
    send_request(ReqRestart, '0, '0, '0, '0);
    send_request(ReqTick, '0, '0, '0, '0);

    episode = 0;
    while (requests_sent < 1100) begin
      drain();
      // The first episodes pin the register extremes; later ones pick at random.
      case (episode)
        0: begin cfg_mode = 3'd7; cfg_quantum = 8'd0; cfg_count = 5'd0; end
        1: begin cfg_mode = ModeRr; cfg_quantum = 8'd255; cfg_count = 5'd31; end
        2: begin cfg_mode = ModeRr; cfg_quantum = 8'd1; cfg_count = 5'd16; end
        3: begin cfg_mode = ModeSrtf; cfg_quantum = 8'd2; cfg_count = 5'd16; end
        4: begin cfg_mode = ModePprio; cfg_quantum = 8'd3; cfg_count = 5'd1; end
        default: begin
          cfg_mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                 : 3'($urandom_range(0, 5));
          case ($urandom_range(0, 5))
            0:       cfg_quantum = 8'd0;
            1:       cfg_quantum = 8'd1;
            2:       cfg_quantum = 8'd255;
            default: cfg_quantum = 8'($urandom_range(1, 4));
          endcase
          cfg_count = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(2, 10));
        end
      endcase
      write_reg(AddrMode, {29'd0, cfg_mode});
      write_reg(AddrQuantum, {24'd0, cfg_quantum});
      write_reg(AddrCount, {27'd0, cfg_count});
      calm = ($urandom_range(0, 3) == 0);

      for (int s = 0; s < pred.active_count(); s++)
        if ($urandom_range(0, 3) != 0) load_random_slot(4'(s));
      send_request(ReqRestart, '0, '0, '0, '0);

      // Tick until the run completes, with a cap for runs that hold a long burst or a
      // late arrival; a little noise is mixed in mid-run.
      ticks = 0;
      extra = 0;
      while (ticks < 80 && extra < 2) begin
        if ($urandom_range(0, 24) == 0)
          load_random_slot(4'($urandom));
        else if ($urandom_range(0, 39) == 0)
          send_request(2'd3, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        else
          send_request(ReqTick, '0, '0, '0, '0);
        ticks++;
        if (pred.run_finished()) extra++;
      end
      episode++;
    end

    in_valid_i <= 1'b0;
    wait_cycles = 0;
    while (pred.expected_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (50) @(posedge clk_i);
    if (pred.errors == 0 && pred.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every tick at its worst shift cost plus the
  // longest gaps and stalls on both sides.
  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
